### hdl/sfcp_pkg.sv
// Shared constants and types for the sensor frame checksum parser.
package sfcp_pkg;

    localparam int MAX_FRAME_DEFAULT = 64;

    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h4D;

    localparam int OFS_HDR_FIRST  = 0;
    localparam int OFS_HDR_SECOND = 1;
    localparam int OFS_PM_HI      = 12;
    localparam int OFS_PM_LO      = 13;
    localparam int OFS_HCHO_HI    = 28;
    localparam int OFS_HCHO_LO    = 29;
    localparam int MIN_FRAME      = 3;

    localparam int LEN_W = 7;

    typedef struct packed {
        logic             done;
        logic [15:0]      pm_value;
        logic [15:0]      hcho_raw;
        logic [LEN_W-1:0] frame_length;
    } sfcp_result_t;

endpackage

### hdl/sfcp_frame_tracker.sv
// Frame state, offset capture and checksum match for one byte per beat.
module sfcp_frame_tracker
    import sfcp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         accept,
    input  logic [7:0]   rx_byte,
    output sfcp_result_t result
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] byte_count_reg,    byte_count_next;
    logic [15:0]   running_sum_reg,   running_sum_next;
    logic [7:0]    previous_byte_reg;
    logic [7:0]    header_first_reg,  header_first_next;
    logic [7:0]    header_second_reg, header_second_next;
    logic [15:0]   pm_bytes_reg,      pm_bytes_next;
    logic [15:0]   hcho_bytes_reg,    hcho_bytes_next;

    logic [CW-1:0] count_inc;
    logic [15:0]   earlier;
    logic          done;

    always_comb begin
        header_first_next  = header_first_reg;
        header_second_next = header_second_reg;
        pm_bytes_next      = pm_bytes_reg;
        hcho_bytes_next    = hcho_bytes_reg;
        if (byte_count_reg == CW'(OFS_HDR_FIRST))  header_first_next     = rx_byte;
        if (byte_count_reg == CW'(OFS_HDR_SECOND)) header_second_next    = rx_byte;
        if (byte_count_reg == CW'(OFS_PM_HI))      pm_bytes_next[15:8]   = rx_byte;
        if (byte_count_reg == CW'(OFS_PM_LO))      pm_bytes_next[7:0]    = rx_byte;
        if (byte_count_reg == CW'(OFS_HCHO_HI))    hcho_bytes_next[15:8] = rx_byte;
        if (byte_count_reg == CW'(OFS_HCHO_LO))    hcho_bytes_next[7:0]  = rx_byte;

        count_inc = byte_count_reg + CW'(1);
        // sum of all bytes before the last two
        earlier   = running_sum_reg - {8'h00, previous_byte_reg};

        done = (count_inc >= CW'(MIN_FRAME)) &&
               (earlier[7:0] == rx_byte) &&
               (earlier[15:8] == previous_byte_reg) &&
               (header_first_next == HDR_FIRST) &&
               (header_second_next == HDR_SECOND);

        if (done || (count_inc >= CW'(MAX_FRAME))) begin
            byte_count_next  = '0;
            running_sum_next = '0;
        end else begin
            byte_count_next  = count_inc;
            running_sum_next = running_sum_reg + {8'h00, rx_byte};
        end

        result.done         = done;
        result.pm_value     = pm_bytes_next;
        result.hcho_raw     = hcho_bytes_next;
        result.frame_length = LEN_W'(count_inc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg    <= '0;
            running_sum_reg   <= '0;
            previous_byte_reg <= '0;
            header_first_reg  <= '0;
            header_second_reg <= '0;
            pm_bytes_reg      <= '0;
            hcho_bytes_reg    <= '0;
        end else if (accept) begin
            byte_count_reg    <= byte_count_next;
            running_sum_reg   <= running_sum_next;
            previous_byte_reg <= rx_byte;
            header_first_reg  <= header_first_next;
            header_second_reg <= header_second_next;
            pm_bytes_reg      <= pm_bytes_next;
            hcho_bytes_reg    <= hcho_bytes_next;
        end
    end

endmodule

### hdl/sfcp_out_reg.sv
// Result register holding one completed-frame beat for the output channel.
module sfcp_out_reg
    import sfcp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  sfcp_result_t     result,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [15:0]      m_pm_value,
    output logic [15:0]      m_hcho_raw,
    output logic [LEN_W-1:0] m_frame_length
);

    logic             valid_reg;
    logic [15:0]      pm_reg;
    logic [15:0]      hcho_reg;
    logic [LEN_W-1:0] len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= result.done;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.done) begin
            pm_reg   <= result.pm_value;
            hcho_reg <= result.hcho_raw;
            len_reg  <= result.frame_length;
        end
    end

    assign m_valid        = valid_reg;
    assign m_pm_value     = pm_reg;
    assign m_hcho_raw     = hcho_reg;
    assign m_frame_length = len_reg;

endmodule

### hdl/sensor_frame_checksum_parser.sv
// Top level of the sensor frame checksum parser.
// Takes one received byte per beat while s_ready is high, and tracks a frame
// that opens with 0x42 0x4D and ends when its last two bytes (high, low) equal
// the 16-bit sum of all earlier bytes. A completed frame gives one result beat
// carrying the big-endian values at offsets 12..13 and 28..29 and the frame
// length, in the cycle after its last byte; other bytes give no result. A frame
// that reaches MAX_FRAME bytes without completing restarts silently. The single
// result register decides throughput: a byte is taken whenever that register is
// empty or being emptied in the same cycle, so the rate is one byte per cycle
// while results are drained.
module sensor_frame_checksum_parser
    import sfcp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [15:0]      m_pm_value,
    output logic [15:0]      m_hcho_raw,
    output logic [LEN_W-1:0] m_frame_length
);

    sfcp_result_t result;
    logic         s_accept;

    assign s_ready  = !m_valid || m_ready;
    assign s_accept = s_valid && s_ready;

    sfcp_frame_tracker #(
        .MAX_FRAME(MAX_FRAME)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .rx_byte (s_rx_byte),
        .result  (result)
    );

    sfcp_out_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (s_accept),
        .result         (result),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pm_value     (m_pm_value),
        .m_hcho_raw     (m_hcho_raw),
        .m_frame_length (m_frame_length)
    );

    a_done_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && result.done |=> m_valid)
        else $error("completed frame did not raise m_valid");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result beat stalled");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !s_accept |=> !m_valid)
        else $error("result beat repeated after hand-off");

    a_beat_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && result.done |=> m_pm_value == $past(result.pm_value) &&
            m_hcho_raw == $past(result.hcho_raw))
        else $error("result register lost frame payload");

endmodule
